// ----- rtl/fcwm_pkg.sv -----
// Shared types, codes and helpers of the four-character-word machine.
// Used by fcwm_ctrl, fcwm_datapath and the top level; depends on nothing.
`default_nettype none

package fcwm_pkg;

    localparam int ADDR_W = 7;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 3;
    localparam int KIND_W = 3;

    // request types (input tuser)
    localparam logic [1:0] REQ_NEW  = 2'd0;
    localparam logic [1:0] REQ_LOAD = 2'd1;
    localparam logic [1:0] REQ_EXEC = 2'd2;
    localparam logic [1:0] REQ_DATA = 2'd3;

    // result kinds (output tuser)
    localparam logic [KIND_W-1:0] KIND_DONE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WORD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HALT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WAIT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERR  = 3'd4;

    // two-character opcodes, first character in the upper byte
    localparam logic [15:0] OP_LR = 16'h4C52;
    localparam logic [15:0] OP_SR = 16'h5352;
    localparam logic [15:0] OP_CR = 16'h4352;
    localparam logic [15:0] OP_BT = 16'h4254;
    localparam logic [15:0] OP_GD = 16'h4744;
    localparam logic [15:0] OP_PD = 16'h5044;

    localparam logic [7:0]        CHAR_ZERO   = 8'h30;  // '0'
    localparam logic [7:0]        CHAR_NINE   = 8'h39;  // '9'
    localparam logic [7:0]        CHAR_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0]        CHAR_NUL    = 8'h00;
    localparam logic [WORD_W-1:0] FILL_WORD   = 32'h24242424;

    typedef logic [2:0] t_opc;
    localparam t_opc OPC_LR  = 3'd0;
    localparam t_opc OPC_SR  = 3'd1;
    localparam t_opc OPC_CR  = 3'd2;
    localparam t_opc OPC_BT  = 3'd3;
    localparam t_opc OPC_GD  = 3'd4;
    localparam t_opc OPC_PD  = 3'd5;
    localparam t_opc OPC_BAD = 3'd6;

    typedef struct packed {
        logic              capture;     // latch the input beat
        logic              clear_job;   // mark memory unwritten and clear the machine
        logic              load_write;  // program word into memory
        logic              card_write;  // data word into the pending card block
        logic              halt;        // set the halted flag
        logic              fetch;       // read M[pc], advance pc
        logic              op_read;     // read M[operand]
        logic              load_r;      // R = read data
        logic              compare;     // C = (R == read data)
        logic              store;       // M[operand] = R
        logic              branch;      // pc = operand when C
        logic              gd_start;    // open a card block
        logic              pd_start;    // start a print walk
        logic              pd_read;     // read M[walk]
        logic              pd_next;     // advance the walk
        logic              emit;        // load the output register
        logic              emit_word;   // output carries the printed word
        logic [KIND_W-1:0] emit_kind;
        logic              emit_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       addr_bad;
        logic       awaiting;
        logic       halted;
        logic       pc_bad;
        logic       last_in;
        t_opc       op;
        logic       opnd_ok;
        logic       walk_done;
        logic       pd_cnt_zero;
        logic       pd_stop;
        logic       out_free;
    } t_stat;

    // keep the first n characters (top bytes), NUL the rest
    function automatic logic [WORD_W-1:0] keep_top(input logic [WORD_W-1:0] w,
                                                   input logic [CNT_W-1:0] n);
        logic [WORD_W-1:0] m;
        case (n)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'hFF00_0000;
            3'd2:    m = 32'hFFFF_0000;
            3'd3:    m = 32'hFFFF_FF00;
            default: m = 32'hFFFF_FFFF;
        endcase
        return w & m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fcwm_ctrl.sv -----
// Sequencer of the four-character-word machine: walks each request through
// dispatch, decode, operand access, print walk and result emission.
// Depends on fcwm_pkg; drives fcwm_datapath through t_cmd, reads t_stat.
`default_nettype none

module fcwm_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_s_tvalid,
    output logic           o_s_tready,
    input  fcwm_pkg::t_stat i_stat,
    output fcwm_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_OPWB   = 3'd3;
    localparam logic [2:0] S_PD_RD  = 3'd4;
    localparam logic [2:0] S_PD_CHK = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]                     r_state, n_state;
    logic [fcwm_pkg::KIND_W-1:0]    r_kind, n_kind;
    logic                           r_wb_cmp, n_wb_cmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_wb_cmp <= n_wb_cmp;
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        n_state    = r_state;
        n_kind     = r_kind;
        n_wb_cmp   = r_wb_cmp;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_EMIT;
                unique case (i_stat.req)
                    fcwm_pkg::REQ_NEW: begin
                        o_cmd.clear_job = 1'b1;
                        n_kind          = fcwm_pkg::KIND_DONE;
                    end
                    fcwm_pkg::REQ_LOAD: begin
                        if (i_stat.addr_bad) begin
                            n_kind = fcwm_pkg::KIND_ERR;
                        end else begin
                            o_cmd.load_write = 1'b1;
                            n_kind           = fcwm_pkg::KIND_DONE;
                        end
                    end
                    fcwm_pkg::REQ_EXEC: begin
                        if (i_stat.halted) begin
                            n_kind = fcwm_pkg::KIND_HALT;
                        end else if (i_stat.awaiting) begin
                            n_kind = fcwm_pkg::KIND_WAIT;
                        end else if (i_stat.pc_bad) begin
                            o_cmd.halt = 1'b1;
                            n_kind     = fcwm_pkg::KIND_ERR;
                        end else begin
                            o_cmd.fetch = 1'b1;
                            n_state     = S_DECODE;
                        end
                    end
                    fcwm_pkg::REQ_DATA: begin
                        if (!i_stat.awaiting) begin
                            n_kind = fcwm_pkg::KIND_ERR;
                        end else begin
                            o_cmd.card_write = 1'b1;
                            n_kind = i_stat.last_in ? fcwm_pkg::KIND_DONE
                                                    : fcwm_pkg::KIND_WAIT;
                        end
                    end
                endcase
            end
            S_DECODE: begin
                n_state = S_EMIT;
                n_kind  = fcwm_pkg::KIND_DONE;
                if (i_stat.op == fcwm_pkg::OPC_BAD) begin
                    o_cmd.halt = 1'b1;
                    n_kind     = fcwm_pkg::KIND_HALT;
                end else if (!i_stat.opnd_ok) begin
                    o_cmd.halt = 1'b1;
                    n_kind     = fcwm_pkg::KIND_ERR;
                end else begin
                    unique case (i_stat.op)
                        fcwm_pkg::OPC_LR: begin
                            o_cmd.op_read = 1'b1;
                            n_wb_cmp      = 1'b0;
                            n_state       = S_OPWB;
                        end
                        fcwm_pkg::OPC_CR: begin
                            o_cmd.op_read = 1'b1;
                            n_wb_cmp      = 1'b1;
                            n_state       = S_OPWB;
                        end
                        fcwm_pkg::OPC_SR: o_cmd.store  = 1'b1;
                        fcwm_pkg::OPC_BT: o_cmd.branch = 1'b1;
                        fcwm_pkg::OPC_GD: begin
                            o_cmd.gd_start = 1'b1;
                            n_kind         = fcwm_pkg::KIND_WAIT;
                        end
                        fcwm_pkg::OPC_PD: begin
                            o_cmd.pd_start = 1'b1;
                            n_state        = S_PD_RD;
                        end
                        default: begin
                            o_cmd.halt = 1'b1;
                            n_kind     = fcwm_pkg::KIND_HALT;
                        end
                    endcase
                end
            end
            S_OPWB: begin
                // read data of the operand word is valid now
                if (r_wb_cmp) begin
                    o_cmd.compare = 1'b1;
                end else begin
                    o_cmd.load_r = 1'b1;
                end
                n_kind  = fcwm_pkg::KIND_DONE;
                n_state = S_EMIT;
            end
            S_PD_RD: begin
                if (i_stat.walk_done) begin
                    n_kind  = fcwm_pkg::KIND_DONE;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.pd_read = 1'b1;
                    n_state       = S_PD_CHK;
                end
            end
            S_PD_CHK: begin
                if (i_stat.pd_cnt_zero) begin
                    n_kind  = fcwm_pkg::KIND_DONE;
                    n_state = S_EMIT;
                end else if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_word = 1'b1;
                    o_cmd.emit_kind = fcwm_pkg::KIND_WORD;
                    if (i_stat.pd_stop) begin
                        n_kind  = fcwm_pkg::KIND_DONE;
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.pd_next = 1'b1;
                        n_state       = S_PD_RD;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = r_kind;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result emitted into a full output register");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> (r_state == S_IDLE))
        else $error("final result not followed by idle");

    a_pd_chk_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PD_CHK) |->
            ($past(r_state) == S_PD_RD || $past(r_state) == S_PD_CHK))
        else $error("print check entered without a walk read");

endmodule

`default_nettype wire

// ----- rtl/fcwm_datapath.sv -----
// Datapath of the four-character-word machine: word memory with valid bits,
// machine registers, instruction decode, card and print pointers, output
// register. Depends on fcwm_pkg; commanded by fcwm_ctrl.
`default_nettype none

module fcwm_datapath #(
    parameter int MEM_WORDS   = 100,
    parameter int BLOCK_WORDS = 10
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  fcwm_pkg::t_cmd                    i_cmd,
    output fcwm_pkg::t_stat                   o_stat,
    input  wire  [1:0]                        i_req,
    input  wire  [fcwm_pkg::ADDR_W-1:0]       i_address,
    input  wire  [fcwm_pkg::WORD_W-1:0]       i_word,
    input  wire  [fcwm_pkg::CNT_W-1:0]        i_byte_count,
    input  wire                               i_last,
    input  wire                               i_m_tready,
    output logic                              o_m_tvalid,
    output logic [fcwm_pkg::KIND_W-1:0]       o_kind,
    output logic [fcwm_pkg::WORD_W-1:0]       o_out_word,
    output logic [fcwm_pkg::CNT_W-1:0]        o_out_bytes,
    output logic                              o_last_out,
    output logic                              o_compare_flag,
    output logic [fcwm_pkg::ADDR_W-1:0]       o_pc
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [fcwm_pkg::ADDR_W-1:0] MEM_LIM = fcwm_pkg::ADDR_W'(MEM_WORDS);
    localparam logic [fcwm_pkg::ADDR_W:0]   BLK     = (fcwm_pkg::ADDR_W + 1)'(BLOCK_WORDS);

    // captured request
    logic [1:0]                     r_req;
    logic [fcwm_pkg::ADDR_W-1:0]    r_addr;
    logic [fcwm_pkg::WORD_W-1:0]    r_word;
    logic [fcwm_pkg::CNT_W-1:0]     r_cnt;
    logic                           r_last;

    // machine state
    logic [fcwm_pkg::ADDR_W-1:0]    r_pc;
    logic [fcwm_pkg::WORD_W-1:0]    r_reg;
    logic                           r_cmp;
    logic                           r_halted;
    logic                           r_awaiting;
    logic [fcwm_pkg::ADDR_W-1:0]    r_card_ptr;
    logic [fcwm_pkg::ADDR_W-1:0]    r_card_end;
    logic [fcwm_pkg::ADDR_W-1:0]    r_walk;
    logic [fcwm_pkg::ADDR_W-1:0]    r_walk_end;

    // memory
    logic [fcwm_pkg::WORD_W-1:0]    r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0]           r_valid;
    logic [fcwm_pkg::WORD_W-1:0]    r_rdata;
    logic                           r_rbit;

    // output register
    logic                           r_out_valid;
    logic [fcwm_pkg::KIND_W-1:0]    r_out_kind;
    logic [fcwm_pkg::WORD_W-1:0]    r_out_word;
    logic [fcwm_pkg::CNT_W-1:0]     r_out_bytes;
    logic                           r_out_last;
    logic                           r_out_cmp;
    logic [fcwm_pkg::ADDR_W-1:0]    r_out_pc;

    logic [fcwm_pkg::WORD_W-1:0]    rd;
    logic [7:0]                     d1, d2;
    logic                           dig_ok;
    logic [fcwm_pkg::ADDR_W-1:0]    opnd, base, blk_end;
    logic [fcwm_pkg::ADDR_W:0]      blk_sum;
    fcwm_pkg::t_opc                 op;
    logic [3:0]                     is_stop;
    logic [fcwm_pkg::CNT_W-1:0]     pd_cnt;
    logic                           card_in;
    logic                           out_free;
    logic                           we, re;
    logic [fcwm_pkg::ADDR_W-1:0]    wa, ra;
    logic [fcwm_pkg::WORD_W-1:0]    wd;

    // never-written words read as the fill pattern
    assign rd = r_rbit ? r_rdata : fcwm_pkg::FILL_WORD;

    // instruction decode
    always_comb begin
        case (rd[31:16])
            fcwm_pkg::OP_LR: op = fcwm_pkg::OPC_LR;
            fcwm_pkg::OP_SR: op = fcwm_pkg::OPC_SR;
            fcwm_pkg::OP_CR: op = fcwm_pkg::OPC_CR;
            fcwm_pkg::OP_BT: op = fcwm_pkg::OPC_BT;
            fcwm_pkg::OP_GD: op = fcwm_pkg::OPC_GD;
            fcwm_pkg::OP_PD: op = fcwm_pkg::OPC_PD;
            default:         op = fcwm_pkg::OPC_BAD;
        endcase
    end

    assign d1     = rd[15:8];
    assign d2     = rd[7:0];
    assign dig_ok = (d1 >= fcwm_pkg::CHAR_ZERO) && (d1 <= fcwm_pkg::CHAR_NINE) &&
                    (d2 >= fcwm_pkg::CHAR_ZERO) && (d2 <= fcwm_pkg::CHAR_NINE);
    // tens * 10 + units, as shifts
    assign opnd    = {d1[3:0], 3'b000} + {2'b00, d1[3:0], 1'b0} + {3'b000, d2[3:0]};
    assign base    = fcwm_pkg::ADDR_W'((opnd / BLOCK_WORDS) * BLOCK_WORDS);
    assign blk_sum = {1'b0, base} + BLK;
    assign blk_end = (blk_sum > {1'b0, MEM_LIM}) ? MEM_LIM
                                                 : blk_sum[fcwm_pkg::ADDR_W-1:0];

    // leading printable characters of the word under the print walk
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            is_stop[j] = (rd[31-8*j -: 8] == fcwm_pkg::CHAR_NUL) ||
                         (rd[31-8*j -: 8] == fcwm_pkg::CHAR_DOLLAR);
        end
        if (is_stop[0]) begin
            pd_cnt = 3'd0;
        end else if (is_stop[1]) begin
            pd_cnt = 3'd1;
        end else if (is_stop[2]) begin
            pd_cnt = 3'd2;
        end else if (is_stop[3]) begin
            pd_cnt = 3'd3;
        end else begin
            pd_cnt = 3'd4;
        end
    end

    assign card_in  = r_card_ptr < r_card_end;
    assign out_free = !r_out_valid || i_m_tready;

    // memory port selection
    always_comb begin
        we = 1'b0;
        wa = r_addr;
        wd = r_word;
        if (i_cmd.load_write) begin
            we = 1'b1;
        end else if (i_cmd.card_write && card_in) begin
            we = 1'b1;
            wa = r_card_ptr;
            wd = fcwm_pkg::keep_top(r_word, r_cnt);
        end else if (i_cmd.store) begin
            we = 1'b1;
            wa = opnd;
            wd = r_reg;
        end
    end

    assign re = i_cmd.fetch || i_cmd.op_read || i_cmd.pd_read;
    assign ra = i_cmd.fetch ? r_pc : (i_cmd.op_read ? opnd : r_walk);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa[AW-1:0]] <= wd;
        end
        if (re) begin
            r_rdata <= r_mem[ra[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_rbit <= r_valid[ra[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear_job) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[wa[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req;
            r_addr <= i_address;
            r_word <= i_word;
            r_cnt  <= i_byte_count;
            r_last <= i_last;
        end
        if (i_cmd.pd_start) begin
            r_walk     <= base;
            r_walk_end <= blk_end;
        end else if (i_cmd.pd_next) begin
            r_walk <= r_walk + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_job) begin
            r_pc       <= '0;
            r_reg      <= '0;
            r_cmp      <= 1'b0;
            r_awaiting <= 1'b0;
            r_card_ptr <= '0;
            r_card_end <= '0;
            r_halted   <= !i_rst_n;
        end else begin
            if (i_cmd.fetch) begin
                r_pc <= r_pc + 7'd1;
            end
            if (i_cmd.branch && r_cmp) begin
                r_pc <= opnd;
            end
            if (i_cmd.halt) begin
                r_halted <= 1'b1;
            end
            if (i_cmd.load_r) begin
                r_reg <= rd;
            end
            if (i_cmd.compare) begin
                r_cmp <= (r_reg == rd);
            end
            if (i_cmd.card_write) begin
                if (card_in) begin
                    r_card_ptr <= r_card_ptr + 7'd1;
                end
                if (r_last) begin
                    r_awaiting <= 1'b0;
                end
            end
            if (i_cmd.gd_start) begin
                r_awaiting <= 1'b1;
                r_card_ptr <= base;
                r_card_end <= blk_end;
            end
        end
    end

    // output register: loaded on emit, dropped when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind  <= i_cmd.emit_kind;
            r_out_word  <= i_cmd.emit_word ? fcwm_pkg::keep_top(rd, pd_cnt) : '0;
            r_out_bytes <= i_cmd.emit_word ? pd_cnt : '0;
            r_out_last  <= i_cmd.emit_last;
            r_out_cmp   <= r_cmp;
            r_out_pc    <= r_pc;
        end
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_out_word     = r_out_word;
    assign o_out_bytes    = r_out_bytes;
    assign o_last_out     = r_out_last;
    assign o_compare_flag = r_out_cmp;
    assign o_pc           = r_out_pc;

    always_comb begin
        o_stat             = '0;
        o_stat.req         = r_req;
        o_stat.addr_bad    = r_addr >= MEM_LIM;
        o_stat.awaiting    = r_awaiting;
        o_stat.halted      = r_halted;
        o_stat.pc_bad      = r_pc >= MEM_LIM;
        o_stat.last_in     = r_last;
        o_stat.op          = op;
        o_stat.opnd_ok     = dig_ok && (opnd < MEM_LIM);
        o_stat.walk_done   = r_walk >= r_walk_end;
        o_stat.pd_cnt_zero = pd_cnt == 3'd0;
        o_stat.pd_stop     = pd_cnt != 3'd4;
        o_stat.out_free    = out_free;
    end

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= MEM_LIM)
        else $error("program counter ran past memory end");

    a_card_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.card_write |-> r_awaiting)
        else $error("card word written with no card pending");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (wa < MEM_LIM))
        else $error("memory write outside the word memory");

endmodule

`default_nettype wire

// ----- rtl/four_char_word_machine_step.sv -----
// Four-character-word teaching machine, one request per input beat.
// Requests (s tuser): new job, load a program word, execute one instruction,
// or supply one data word to a pending GD. Each request yields one or more
// result beats on the m side, the last one flagged by tlast; a PD returns one
// beat per printed word and a closing done beat. Memory is a single-port word
// store of MEM_WORDS entries with one valid bit per word, so reset and a new
// job take effect at once, with no clearing pass: unwritten words read '$$$$'.
// Steps from accept to the next accept: new job, load and data requests pass
// through dispatch and emit; an execute adds a decode step, LR and CR add an
// operand read and write-back through the same memory port, and PD walks the
// block words, each with one memory read and one character check. The input
// is accepted again as soon as the last result sits in the output register,
// even if it is not yet taken.
// Depends on fcwm_pkg, fcwm_ctrl and fcwm_datapath.
`default_nettype none

module four_char_word_machine_step #(
    parameter int MEM_WORDS   = 100,
    parameter int BLOCK_WORDS = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request side
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [47:0] i_s_tdata,   // address[6:0], word_in[38:7], byte_count[41:39], 0
    input  wire  [1:0]  i_s_tuser,   // req_type[1:0]
    input  wire         i_s_tlast,   // last_in
    // result side
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [47:0] o_m_tdata,   // out_word[31:0], out_bytes[34:32],
                                     // compare_flag[35], pc[42:36], 0
    output logic [2:0]  o_m_tuser,   // kind[2:0]
    output logic        o_m_tlast    // last_out
);

    fcwm_pkg::t_cmd  cmd;
    fcwm_pkg::t_stat stat;

    logic [fcwm_pkg::WORD_W-1:0] out_word;
    logic [fcwm_pkg::CNT_W-1:0]  out_bytes;
    logic                        compare_flag;
    logic [fcwm_pkg::ADDR_W-1:0] pc;

    // sequencer: one request in flight at a time
    fcwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // memory, machine registers and the output register
    fcwm_datapath #(
        .MEM_WORDS   (MEM_WORDS),
        .BLOCK_WORDS (BLOCK_WORDS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_req          (i_s_tuser),
        .i_address      (i_s_tdata[6:0]),
        .i_word         (i_s_tdata[38:7]),
        .i_byte_count   (i_s_tdata[41:39]),
        .i_last         (i_s_tlast),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_kind         (o_m_tuser),
        .o_out_word     (out_word),
        .o_out_bytes    (out_bytes),
        .o_last_out     (o_m_tlast),
        .o_compare_flag (compare_flag),
        .o_pc           (pc)
    );

    // pack the result beat, zero pad to whole bytes
    assign o_m_tdata = {5'b00000, pc, compare_flag, out_bytes, out_word};

endmodule

`default_nettype wire
